// ----- sv/cmr_pkg.sv -----
// Shared types and constants for the compaction index remapper.
// No dependencies; cmr_front, cmr_back, the top level and the testbench import it.
package cmr_pkg;

  // Width of index values and compacted positions
  localparam int FIELD_W = 12;

  // Default size of the removed-count table
  localparam int MAX_ITEMS_DEF = 4096;

  // Depth of the queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // Request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_SOURCE  = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               remove_flag;
    logic [FIELD_W-1:0] index_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] remapped_value;
    logic [FIELD_W-1:0] out_position;
    logic               bad_index;
  } out_item_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] pos;
    logic               bad;
    logic               lookup;
  } cmd_t;

endpackage

// ----- sv/cmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/cmr_front.sv -----
// Front of the remapper: accepts requests, keeps the counters and the
// removed-count table, and classifies source requests. Uses cmr_pkg, cmr_ram.
module cmr_front #(
  parameter int MAX_ITEMS = cmr_pkg::MAX_ITEMS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_push,
  input  cmr_pkg::in_item_t                         in_item,
  output logic                                      in_full,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic                                      cfg_data,
  input  logic [$clog2(cmr_pkg::QUEUE_DEPTH+1)-1:0] q_cnt,
  output logic                                      cmd_push,
  output cmr_pkg::cmd_t                             cmd,
  output logic [$clog2(MAX_ITEMS+1)-1:0]            cmd_removed
);

  import cmr_pkg::*;

  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] tl_r, tl_nxt;   // target entries loaded
  logic [CW-1:0] tr_r, tr_nxt;   // target entries removed
  logic [CW-1:0] sp_r, sp_nxt;   // source requests counted
  logic [CW-1:0] sr_r, sr_nxt;   // source requests removed
  logic          remap_r;
  logic          s1_v_r, s1_v_nxt;
  cmd_t          s1_cmd_r, s1_cmd_nxt;

  logic          accept;
  logic          src_full;
  logic          val_bad;
  logic [CW-1:0] tr_inc;
  logic          ram_we;
  logic          ram_re;

  // Hold requests while the queue cannot take one more
  assign in_full   = (QCW'(QUEUE_DEPTH) - q_cnt) <= QCW'(s1_v_r);
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;

  assign src_full = sp_r >= CW'(MAX_ITEMS);
  assign val_bad  = (CMPW'(in_item.index_value) >= CMPW'(tl_r))
                 || (CMPW'(in_item.index_value) >= CMPW'(MAX_ITEMS));
  assign tr_inc   = tr_r + CW'(in_item.remove_flag);

  // Classify the request and advance the counters
  always_comb begin
    tl_nxt     = tl_r;
    tr_nxt     = tr_r;
    sp_nxt     = sp_r;
    sr_nxt     = sr_r;
    s1_v_nxt   = 1'b0;
    s1_cmd_nxt = s1_cmd_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (accept) begin
      case (in_item.req_type)
        REQ_RESTART: begin
          tl_nxt = '0;
          tr_nxt = '0;
          sp_nxt = '0;
          sr_nxt = '0;
        end
        REQ_LOAD: begin
          if (tl_r < CW'(MAX_ITEMS)) begin
            tr_nxt = tr_inc;
            tl_nxt = tl_r + CW'(1);
            ram_we = 1'b1;
          end
        end
        REQ_SOURCE: begin
          if (in_item.remove_flag) begin
            // Drop and count the removed request
            if (!src_full) begin
              sp_nxt = sp_r + CW'(1);
              sr_nxt = sr_r + CW'(1);
            end
          end else begin
            s1_v_nxt          = 1'b1;
            s1_cmd_nxt.value  = in_item.index_value;
            s1_cmd_nxt.pos    = FIELD_W'(sp_r - sr_r);
            s1_cmd_nxt.bad    = 1'b0;
            s1_cmd_nxt.lookup = 1'b0;
            if (src_full) begin
              s1_cmd_nxt.bad = 1'b1;
            end else begin
              sp_nxt = sp_r + CW'(1);
              if (remap_r) begin
                if (val_bad) begin
                  s1_cmd_nxt.bad = 1'b1;
                end else begin
                  s1_cmd_nxt.lookup = 1'b1;
                  ram_re            = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Removed-count table, read in the cycle after the source request
  cmr_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ITEMS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tl_r[AW-1:0]),
    .wdata (tr_inc),
    .re    (ram_re),
    .raddr (AW'(in_item.index_value)),
    .rdata (cmd_removed)
  );

  // Counter and stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r    <= '0;
      tr_r    <= '0;
      sp_r    <= '0;
      sr_r    <= '0;
      remap_r <= 1'b1;
      s1_v_r  <= 1'b0;
    end else begin
      tl_r   <= tl_nxt;
      tr_r   <= tr_nxt;
      sp_r   <= sp_nxt;
      sr_r   <= sr_nxt;
      s1_v_r <= s1_v_nxt;
      if (cfg_valid && cfg_ready) begin
        remap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
  end

  assign cmd_push = s1_v_r;
  assign cmd      = s1_cmd_r;

`ifndef NO_ASSERTIONS
  // A staged request always finds room in the queue
  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (q_cnt < QCW'(QUEUE_DEPTH)))
    else $error("front pushed into a full queue");

  // Removed counts never pass their totals
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    (sr_r <= sp_r) && (tr_r <= tl_r) && (sp_r <= CW'(MAX_ITEMS)))
    else $error("counter ordering broken");

  // A table lookup only follows an in-range source request
  a_lookup_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (!val_bad && !src_full && remap_r))
    else $error("table read out of range");
`endif

endmodule

// ----- sv/cmr_back.sv -----
// Back of the remapper: queues classified requests, applies the subtract
// and clamp, and holds the result register. Uses cmr_pkg.
module cmr_back #(
  parameter int MAX_ITEMS = cmr_pkg::MAX_ITEMS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cmd_push,
  input  cmr_pkg::cmd_t                             cmd,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]            cmd_removed,
  output logic [$clog2(cmr_pkg::QUEUE_DEPTH+1)-1:0] q_cnt,
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output cmr_pkg::out_item_t                        out_item
);

  import cmr_pkg::*;

  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW  = $clog2(QUEUE_DEPTH);

  cmd_t          q_cmd_r [QUEUE_DEPTH];
  logic [CW-1:0] q_rem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           out_v_r, out_v_nxt;
  out_item_t      out_r, out_nxt;

  logic           q_pop;
  cmd_t           head;
  logic [CW-1:0]  head_rem;
  logic [CMPW-1:0] val_x;
  logic [CMPW-1:0] rem_x;

  assign head     = q_cmd_r[rp_r];
  assign head_rem = q_rem_r[rp_r];
  assign val_x    = CMPW'(head.value);
  assign rem_x    = CMPW'(head_rem);

  // Advance the queue head whenever the result register frees up
  assign q_pop = (cnt_r != '0) && (!out_v_r || out_pop);

  always_comb begin
    wp_nxt  = cmd_push ? QAW'(wp_r + QAW'(1)) : wp_r;
    rp_nxt  = q_pop ? QAW'(rp_r + QAW'(1)) : rp_r;
    cnt_nxt = cnt_r + QCW'(cmd_push) - QCW'(q_pop);
  end

  // Build the result: renumber, copy or zero on error
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r && !out_pop;
    if (q_pop) begin
      out_v_nxt            = 1'b1;
      out_nxt.out_position = head.pos;
      out_nxt.bad_index    = head.bad;
      if (head.bad) begin
        out_nxt.remapped_value = '0;
      end else if (head.lookup) begin
        out_nxt.remapped_value = (rem_x > val_x) ? '0 : FIELD_W'(val_x - rem_x);
      end else begin
        out_nxt.remapped_value = head.value;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (cmd_push) begin
      q_cmd_r[wp_r] <= cmd;
      q_rem_r[wp_r] <= cmd_removed;
    end
  end

  // Queue pointers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign q_cnt     = cnt_r;
  assign out_empty = !out_v_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  // Queue occupancy stays within its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Occupancy tracks pushes and pops
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      (cnt_r == QCW'($past(cnt_r) + QCW'($past(cmd_push)) - QCW'($past(q_pop)))))
    else $error("queue count out of step");

  // Pointers differ by the occupancy
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != QCW'(QUEUE_DEPTH)) |-> (QAW'(wp_r - rp_r) == QAW'(cnt_r)))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- sv/compaction_index_remapper.sv -----
// Top level of the compaction index remapper; instantiates cmr_front and
// cmr_back. Uses cmr_pkg for the request and result types.
//
// Takes one request per clock while in_full is low. Restart clears the
// counters, load requests fill the removed-count table in order, and source
// requests either drop (flagged) or produce one result with the compacted
// position and the renumbered value. A result passes through the front
// stage, where the table is read, and then the four-entry queue, after which
// it sits in the result register until popped. With out_pop held high the
// block sustains one request per cycle; in_full rises once the queue,
// counting the request in the front stage, has no free entry, so a stalled
// reader holds off at most four results in the queue plus the one in the
// result register.
// remap_enable is written through cfg_valid/cfg_data, which is always ready.
module compaction_index_remapper #(
  parameter int MAX_ITEMS = cmr_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  cmr_pkg::in_item_t   in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output cmr_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  import cmr_pkg::*;

  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic           cmd_push;
  cmd_t           cmd;
  logic [CW-1:0]  cmd_removed;
  logic [QCW-1:0] q_cnt;

  // Accept and classify requests
  cmr_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_item     (in_item),
    .in_full     (in_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_cnt       (q_cnt),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .cmd_removed (cmd_removed)
  );

  // Queue, renumber and deliver results
  cmr_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_push    (cmd_push),
    .cmd         (cmd),
    .cmd_removed (cmd_removed),
    .q_cnt       (q_cnt),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for compaction_index_remapper.
// Depends on cmr_pkg for the request and result types. It predicts every
// result from its own model of the counters and the removed-count table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmr_pkg::*;

  localparam int TBL_SIZE     = MAX_ITEMS_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IN_W         = $bits(in_item_t);
  localparam int DRAIN_WAIT   = 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // Predictor state: removed-count table, counters and the remap register
  logic [12:0] removed_tbl [TBL_SIZE];
  int unsigned loaded_cnt;
  int unsigned tgt_removed;
  int unsigned src_pos;
  int unsigned src_dropped;
  bit          remap_on;

  out_item_t expected_results[$];
  out_item_t exp_res;
  int        errors          = 0;
  int        requests_sent   = 0;
  int        results_checked = 0;

  // Idle control for both sides
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_gap  = 0;
  int rx_hold = 0;

  compaction_index_remapper #(
    .MAX_ITEMS(TBL_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5ns clk = ~clk;

  function automatic in_item_t make_req(logic [1:0] kind, logic flag, logic [11:0] value);
    in_item_t r;
    r.req_type    = kind;
    r.remove_flag = flag;
    r.index_value = value;
    return r;
  endfunction

  // Advance the predicted state by one accepted request; queue any result
  task automatic predict_request(input in_item_t r);
    out_item_t   res;
    int unsigned value;
    int unsigned removed;
    bit          full;
    res   = '0;
    value = r.index_value;
    case (r.req_type)
      REQ_RESTART: begin
        loaded_cnt  = 0;
        tgt_removed = 0;
        src_pos     = 0;
        src_dropped = 0;
      end
      REQ_LOAD: begin
        if (loaded_cnt < TBL_SIZE) begin
          tgt_removed += r.remove_flag;
          removed_tbl[loaded_cnt] = 13'(tgt_removed);
          loaded_cnt++;
        end
      end
      REQ_SOURCE: begin
        full = (src_pos >= TBL_SIZE);
        if (r.remove_flag) begin
          if (!full) begin
            src_pos++;
            src_dropped++;
          end
        end else begin
          res.out_position = FIELD_W'(src_pos - src_dropped);
          if (full) begin
            res.bad_index = 1'b1;
          end else begin
            src_pos++;
            if (!remap_on) begin
              res.remapped_value = r.index_value;
            end else if (value >= loaded_cnt) begin
              res.bad_index = 1'b1;
            end else begin
              removed = removed_tbl[value];
              res.remapped_value = (removed > value) ? '0 : FIELD_W'(value - removed);
            end
          end
          expected_results.insert(expected_results.size(), res);
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic push_request(input in_item_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (in_full);
    predict_request(r);
    requests_sent++;
  endtask

  // Drop push and wait until every expected result has come back
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the remap register; only called with the block idle
  task automatic write_remap(input logic enable);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= enable;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    remap_on = enable;
  endtask

  function automatic logic [11:0] pick_value();
    if (loaded_cnt > 0 && $urandom_range(0, 9) != 0)
      return 12'($urandom_range(0, loaded_cnt - 1));
    return 12'($urandom_range(0, 4095));
  endfunction

  // Edge cases: clamp, out-of-range values, drops, unused code, restart
  task automatic test_directed();
    push_request(make_req(REQ_RESTART, 1'b0, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b1, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b1, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b0, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b1, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b0, 12'd4095));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd0));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd1));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd4));
    push_request(make_req(REQ_SOURCE, 1'b1, 12'd2));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd5));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd4095));
    push_request(make_req(REQ_UNUSED, 1'b1, 12'd4095));
    push_request(make_req(REQ_UNUSED, 1'b0, 12'd0));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd3));
    push_request(make_req(REQ_RESTART, 1'b1, 12'd4095));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b0, 12'd0));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd0));
    drain_results();
  endtask

  // Pass-through with remapping off, then back on
  task automatic test_remap_config();
    write_remap(1'b0);
    push_request(make_req(REQ_RESTART, 1'b0, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b1, 12'd0));
    push_request(make_req(REQ_LOAD, 1'b1, 12'd0));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd4095));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd0));
    push_request(make_req(REQ_SOURCE, 1'b1, 12'd1));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd2730));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd1365));
    write_remap(1'b1);
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd1));
    push_request(make_req(REQ_SOURCE, 1'b0, 12'd4095));
    drain_results();
  endtask

  // Stall the reader so the block fills, then pause until all results are out
  task automatic test_backpressure();
    int i;
    push_request(make_req(REQ_RESTART, 1'b0, 12'd0));
    for (i = 0; i < 16; i++)
      push_request(make_req(REQ_LOAD, 1'($urandom_range(0, 1)), 12'd0));
    tx_idle = 1'b0;
    rx_hold = HOLD_CYCLES;
    for (i = 0; i < 40; i++)
      push_request(make_req(REQ_SOURCE, 1'b0, 12'($urandom_range(0, 15))));
    drain_results();
    tx_idle = 1'b1;
  endtask

  // Well-formed passes with random content, mixed with noise requests
  task automatic test_random_passes();
    int       sent;
    int       n_load;
    int       n_src;
    int       density;
    int       i;
    in_item_t r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0)
        write_remap(1'($urandom_range(0, 1)));
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      density = $urandom_range(0, 4);
      n_load  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      n_src   = $urandom_range(1, 60);
      push_request(make_req(REQ_RESTART, 1'($urandom_range(0, 1)),
                            12'($urandom_range(0, 4095))));
      for (i = 0; i < n_load; i++)
        push_request(make_req(REQ_LOAD, $urandom_range(0, 3) < density,
                              12'($urandom_range(0, 4095))));
      sent += n_load + 1;
      for (i = 0; i < n_src; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          r = in_item_t'(IN_W'($urandom()));
        end else begin
          r = make_req(REQ_SOURCE, $urandom_range(0, 3) == 0, pick_value());
        end
        push_request(r);
        if (r.req_type != REQ_UNUSED) sent++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Reader: draw a gap per result, honor a long hold-off when requested
  always @(posedge clk) begin
    if (out_pop && !out_empty) rx_gap = rx_idle ? $urandom_range(0, 4) : 0;
    if (rx_hold > 0) begin
      rx_hold--;
      out_pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.remapped_value !== exp_res.remapped_value) begin
          errors++;
          $display("%0t: remapped_value expected %0d got %0d", $time,
                   exp_res.remapped_value, out_item.remapped_value);
        end
        if (out_item.out_position !== exp_res.out_position) begin
          errors++;
          $display("%0t: out_position expected %0d got %0d", $time,
                   exp_res.out_position, out_item.out_position);
        end
        if (out_item.bad_index !== exp_res.bad_index) begin
          errors++;
          $display("%0t: bad_index expected %0b got %0b", $time,
                   exp_res.bad_index, out_item.bad_index);
        end
      end
    end
  end

  // End the run if no request or result moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL compaction_index_remapper");
    $finish;
  end

  initial begin
    loaded_cnt  = 0;
    tgt_removed = 0;
    src_pos     = 0;
    src_dropped = 0;
    remap_on    = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_remap_config();
    test_backpressure();
    test_random_passes();
    drain_results();

    $display("Covered %0d requests and %0d checked results: edge cases, both remap settings,",
             requests_sent, results_checked);
    $display("a long reader hold-off with a full block, and random passes with idling.");
    if (errors == 0) begin
      $display("PASS compaction_index_remapper");
    end else begin
      $display("FAIL compaction_index_remapper");
    end
    $finish;
  end

endmodule
